FILE: hw/rtl/rfb_pkg.sv
// Types and constants for the radix-4 Q15 FFT butterfly.
package rfb_pkg;

  localparam int unsigned NumSamples = 4;
  localparam int unsigned NumStages = 4;

  // 2 * 8191: rounding doubling multiply-high by 8191/32768
  localparam logic signed [15:0] ScaleMul = 16'sd16382;
  localparam logic signed [31:0] ScaleRnd = 32'sd32768;
  localparam logic signed [31:0] TwRnd = 32'sd16384;

  // twiddles W16^(m*k), rows m = 1..3, columns k = 0..3
  localparam logic signed [15:0] TwRe [1:3][4] = '{
    '{16'sd32767, 16'sd30273, 16'sd23170, 16'sd12539},
    '{16'sd32767, 16'sd23170, 16'sd0, -16'sd23170},
    '{16'sd32767, 16'sd12539, -16'sd23170, -16'sd30273}
  };
  localparam logic signed [15:0] TwIm [1:3][4] = '{
    '{16'sd0, -16'sd12539, -16'sd23170, -16'sd30273},
    '{16'sd0, -16'sd23170, -16'sd32767, -16'sd23170},
    '{16'sd0, -16'sd30273, -16'sd23170, 16'sd12539}
  };

  typedef struct packed {
    logic [1:0]         lane;
    logic signed [15:0] x0_re;
    logic signed [15:0] x0_im;
    logic signed [15:0] x1_re;
    logic signed [15:0] x1_im;
    logic signed [15:0] x2_re;
    logic signed [15:0] x2_im;
    logic signed [15:0] x3_re;
    logic signed [15:0] x3_im;
    logic               end_of_batch;
  } in_t;

  typedef struct packed {
    logic signed [15:0] y0_re;
    logic signed [15:0] y0_im;
    logic signed [15:0] y1_re;
    logic signed [15:0] y1_im;
    logic signed [15:0] y2_re;
    logic signed [15:0] y2_im;
    logic signed [15:0] y3_re;
    logic signed [15:0] y3_im;
    logic               batch_done;
  } out_t;

endpackage

FILE: hw/rtl/radix4_fft_butterfly_q15.sv
// Pipelined radix-4 forward FFT butterfly on four Q15 complex samples.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | rfb_pkg::in_t
//   out     | output    | out_valid_o / out_stall_i | rfb_pkg::out_t
//
// Four register stages: scale, twiddle multiply, round, combine.
// One transaction per cycle while out_stall_i is low; each passes the four registers in order to out_valid_o.
// The stage-valid chain lets a stage load whenever it or any stage after it is free, or out_stall_i is low.
// out_stall_i holds the output register; bubbles ahead of it still collapse.
// rst_ni clears the stage valid bits only; data registers are not reset.
module radix4_fft_butterfly_q15 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rfb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rfb_pkg::out_t out_data_o
);

  logic [rfb_pkg::NumStages-1:0] v_q;
  logic [rfb_pkg::NumStages-1:0] rdy;

  // stage 1: scaled samples
  logic signed [15:0] s_re_d [rfb_pkg::NumSamples];
  logic signed [15:0] s_im_d [rfb_pkg::NumSamples];
  logic signed [15:0] s_re_q [rfb_pkg::NumSamples];
  logic signed [15:0] s_im_q [rfb_pkg::NumSamples];
  logic [1:0]         lane_q;
  logic               eob1_q;

  // stage 2: twiddle partial products
  logic signed [31:0] prr_d [1:3];
  logic signed [31:0] pii_d [1:3];
  logic signed [31:0] pri_d [1:3];
  logic signed [31:0] pir_d [1:3];
  logic signed [31:0] prr_q [1:3];
  logic signed [31:0] pii_q [1:3];
  logic signed [31:0] pri_q [1:3];
  logic signed [31:0] pir_q [1:3];
  logic signed [15:0] a0_re2_q;
  logic signed [15:0] a0_im2_q;
  logic               eob2_q;

  // stage 3: rounded butterfly inputs
  logic signed [15:0] a_re_d [rfb_pkg::NumSamples];
  logic signed [15:0] a_im_d [rfb_pkg::NumSamples];
  logic signed [15:0] a_re_q [rfb_pkg::NumSamples];
  logic signed [15:0] a_im_q [rfb_pkg::NumSamples];
  logic               eob3_q;

  // stage 4: output
  rfb_pkg::out_t out_d;
  rfb_pkg::out_t out_q;

  always_comb begin
    rdy[rfb_pkg::NumStages-1] = !v_q[rfb_pkg::NumStages-1] || !out_stall_i;
    for (int i = rfb_pkg::NumStages - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[rfb_pkg::NumStages-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < rfb_pkg::NumStages; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 1
  function automatic logic signed [15:0] scale_q15(input logic signed [15:0] x);
    logic signed [31:0] t;
    t = x * rfb_pkg::ScaleMul + rfb_pkg::ScaleRnd;
    return t[31:16];
  endfunction

  always_comb begin
    s_re_d[0] = scale_q15(in_data_i.x0_re);
    s_im_d[0] = scale_q15(in_data_i.x0_im);
    s_re_d[1] = scale_q15(in_data_i.x1_re);
    s_im_d[1] = scale_q15(in_data_i.x1_im);
    s_re_d[2] = scale_q15(in_data_i.x2_re);
    s_im_d[2] = scale_q15(in_data_i.x2_im);
    s_re_d[3] = scale_q15(in_data_i.x3_re);
    s_im_d[3] = scale_q15(in_data_i.x3_im);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
      lane_q <= in_data_i.lane;
      eob1_q <= in_data_i.end_of_batch;
    end
  end

  // stage 2
  always_comb begin
    for (int m = 1; m < rfb_pkg::NumSamples; m++) begin
      prr_d[m] = s_re_q[m] * rfb_pkg::TwRe[m][lane_q];
      pii_d[m] = s_im_q[m] * rfb_pkg::TwIm[m][lane_q];
      pri_d[m] = s_re_q[m] * rfb_pkg::TwIm[m][lane_q];
      pir_d[m] = s_im_q[m] * rfb_pkg::TwRe[m][lane_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      prr_q    <= prr_d;
      pii_q    <= pii_d;
      pri_q    <= pri_d;
      pir_q    <= pir_d;
      a0_re2_q <= s_re_q[0];
      a0_im2_q <= s_im_q[0];
      eob2_q   <= eob1_q;
    end
  end

  // stage 3: only bits 30:15 of the rounded sum survive, so 32-bit wrap is exact
  always_comb begin
    logic signed [31:0] acc_re;
    logic signed [31:0] acc_im;
    a_re_d[0] = a0_re2_q;
    a_im_d[0] = a0_im2_q;
    for (int m = 1; m < rfb_pkg::NumSamples; m++) begin
      acc_re    = prr_q[m] - pii_q[m] + rfb_pkg::TwRnd;
      acc_im    = pri_q[m] + pir_q[m] + rfb_pkg::TwRnd;
      a_re_d[m] = acc_re[30:15];
      a_im_d[m] = acc_im[30:15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a_re_q <= a_re_d;
      a_im_q <= a_im_d;
      eob3_q <= eob2_q;
    end
  end

  // stage 4
  always_comb begin
    logic signed [15:0] s02r, s02i, d02r, d02i, s13r, s13i, d13r, d13i;
    s02r = a_re_q[0] + a_re_q[2];
    s02i = a_im_q[0] + a_im_q[2];
    d02r = a_re_q[0] - a_re_q[2];
    d02i = a_im_q[0] - a_im_q[2];
    s13r = a_re_q[1] + a_re_q[3];
    s13i = a_im_q[1] + a_im_q[3];
    d13r = a_re_q[1] - a_re_q[3];
    d13i = a_im_q[1] - a_im_q[3];
    out_d.y0_re      = s02r + s13r;
    out_d.y0_im      = s02i + s13i;
    out_d.y1_re      = d02r + d13i;
    out_d.y1_im      = d02i - d13r;
    out_d.y2_re      = s02r - s13r;
    out_d.y2_im      = s02i - s13i;
    out_d.y3_re      = d02r - d13i;
    out_d.y3_im      = d02i + d13r;
    out_d.batch_done = eob3_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while a pipeline stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transaction not captured in first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (lane_q == $past(in_data_i.lane)))
    else $error("lane not captured with accepted transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[2] && !rdy[3]) |=> v_q[2] && $stable(a_re_q[1]) && $stable(eob3_q))
    else $error("round stage lost or changed a held transaction");

endmodule

FILE: sim/tb_radix4_fft_butterfly_q15.sv
// Self-checking testbench for the radix-4 Q15 FFT butterfly with random gaps and stalls.
module tb_radix4_fft_butterfly_q15;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ScaleNum = 8191;
  localparam longint TwRound = 16384;
  localparam int RandomItems = 1700;
  localparam int IdleLimit = 2000;
  localparam int TailCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rfb_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rfb_pkg::out_t out_data_o;

  radix4_fft_butterfly_q15 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  rfb_pkg::in_t pending_butterflies[$];
  rfb_pkg::out_t expected_outputs[$];
  logic in_took = 1'b0;
  int drive_cnt = 0;
  int directed_cnt = 0;
  int burst_left = 8;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int result_count = 0;
  int accepted_count = 0;
  int eob_count = 0;
  int lane_hits[4] = '{0, 0, 0, 0};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] scale_q15(logic signed [15:0] v);
    longint p;
    p = longint'(v) * (2 * ScaleNum) + 32768;
    return 16'(p >>> 16);
  endfunction

  function automatic int twiddle_re(int m, logic [1:0] k);
    case (m * 4 + int'(k))
      4, 8, 12: return 32767;
      5:        return 30273;
      6, 9:     return 23170;
      7, 13:    return 12539;
      11, 14:   return -23170;
      15:       return -30273;
      default:  return 0;
    endcase
  endfunction

  function automatic int twiddle_im(int m, logic [1:0] k);
    case (m * 4 + int'(k))
      5:              return -12539;
      6, 9, 11, 14:   return -23170;
      7, 13:          return -30273;
      10:             return -32767;
      15:             return 12539;
      default:        return 0;
    endcase
  endfunction

  function automatic rfb_pkg::out_t fft_butterfly(rfb_pkg::in_t x);
    logic signed [15:0] s_re[4];
    logic signed [15:0] s_im[4];
    logic signed [15:0] a_re[4];
    logic signed [15:0] a_im[4];
    logic signed [15:0] d02r, d02i, s02r, s02i, d13r, d13i, s13r, s13i;
    longint wr, wi, acc_re, acc_im;
    rfb_pkg::out_t y;
    s_re[0] = scale_q15(x.x0_re);
    s_im[0] = scale_q15(x.x0_im);
    s_re[1] = scale_q15(x.x1_re);
    s_im[1] = scale_q15(x.x1_im);
    s_re[2] = scale_q15(x.x2_re);
    s_im[2] = scale_q15(x.x2_im);
    s_re[3] = scale_q15(x.x3_re);
    s_im[3] = scale_q15(x.x3_im);
    a_re[0] = s_re[0];
    a_im[0] = s_im[0];
    for (int m = 1; m < 4; m++) begin
      wr = twiddle_re(m, x.lane);
      wi = twiddle_im(m, x.lane);
      acc_re = longint'(s_re[m]) * wr - longint'(s_im[m]) * wi;
      acc_im = longint'(s_re[m]) * wi + longint'(s_im[m]) * wr;
      a_re[m] = 16'((acc_re + TwRound) >>> 15);
      a_im[m] = 16'((acc_im + TwRound) >>> 15);
    end
    d02r = a_re[0] - a_re[2];
    d02i = a_im[0] - a_im[2];
    s02r = a_re[0] + a_re[2];
    s02i = a_im[0] + a_im[2];
    d13r = a_re[1] - a_re[3];
    d13i = a_im[1] - a_im[3];
    s13r = a_re[1] + a_re[3];
    s13i = a_im[1] + a_im[3];
    y.y0_re = s02r + s13r;
    y.y0_im = s02i + s13i;
    y.y1_re = d02r + d13i;
    y.y1_im = d02i - d13r;
    y.y2_re = s02r - s13r;
    y.y2_im = s02i - s13i;
    y.y3_re = d02r - d13i;
    y.y3_im = d02i + d13r;
    y.batch_done = x.end_of_batch;
    return y;
  endfunction

  task automatic report_error(string msg);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             result_count, name, $signed(got), $signed(want)));
    end
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic rfb_pkg::in_t rand_butterfly(logic [1:0] lane, logic eob);
    rfb_pkg::in_t x;
    x.lane = lane;
    x.x0_re = rand_sample();
    x.x0_im = rand_sample();
    x.x1_re = rand_sample();
    x.x1_im = rand_sample();
    x.x2_re = rand_sample();
    x.x2_im = rand_sample();
    x.x3_re = rand_sample();
    x.x3_im = rand_sample();
    x.end_of_batch = eob;
    return x;
  endfunction

  function automatic rfb_pkg::in_t uniform_butterfly(logic [1:0] lane,
                                                     logic signed [15:0] v, logic eob);
    return '{lane, v, v, v, v, v, v, v, v, eob};
  endfunction

  // driver: hold a stalled transaction, otherwise advance by burst and gap
  always @(negedge clk_i) begin : driver
    logic drive_now;
    logic drain_point;
    drive_now = 1'b0;
    drain_point = (drive_cnt == directed_cnt) || (drive_cnt == directed_cnt + 900);
    if (!(in_valid_i && !in_took)) begin
      if (rst_ni) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_butterflies.size() != 0 &&
                     !(drain_point && expected_outputs.size() != 0)) begin
          drive_now = 1'b1;
        end
      end
      in_valid_i <= drive_now;
      if (drive_now) begin
        in_data_i <= pending_butterflies.pop_front();
        drive_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= $urandom_range(0, 1);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_phase % 5 < 2);
    endcase
  end

  always @(posedge clk_i) begin : monitor
    rfb_pkg::out_t want;
    logic moved;
    moved = 1'b0;
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_outputs.size() == 0) begin
          report_error($sformatf("unexpected result %0d", result_count));
        end else begin
          want = expected_outputs.pop_front();
          check_field("y0_re", out_data_o.y0_re, want.y0_re);
          check_field("y0_im", out_data_o.y0_im, want.y0_im);
          check_field("y1_re", out_data_o.y1_re, want.y1_re);
          check_field("y1_im", out_data_o.y1_im, want.y1_im);
          check_field("y2_re", out_data_o.y2_re, want.y2_re);
          check_field("y2_im", out_data_o.y2_im, want.y2_im);
          check_field("y3_re", out_data_o.y3_re, want.y3_re);
          check_field("y3_im", out_data_o.y3_im, want.y3_im);
          check_field("batch_done", {15'd0, out_data_o.batch_done}, {15'd0, want.batch_done});
        end
        result_count++;
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        expected_outputs.push_back(fft_butterfly(in_data_i));
        accepted_count++;
        lane_hits[in_data_i.lane]++;
        if (in_data_i.end_of_batch) begin
          eob_count++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] ERROR: no transaction for %0d cycles", $time, IdleLimit);
        $display("FAIL radix4_fft_butterfly_q15");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    for (int k = 0; k < 4; k++) begin
      pending_butterflies.push_back(uniform_butterfly(2'(k), 16'sd32767, k == 3));
      pending_butterflies.push_back(uniform_butterfly(2'(k), -16'sd32768, 1'b1));
    end
    pending_butterflies.push_back(uniform_butterfly(2'd0, 16'sd0, 1'b0));
    pending_butterflies.push_back(uniform_butterfly(2'd1, 16'sd1, 1'b0));
    pending_butterflies.push_back(uniform_butterfly(2'd2, -16'sd1, 1'b0));
    pending_butterflies.push_back(uniform_butterfly(2'd3, 16'sd2, 1'b0));
    pending_butterflies.push_back(uniform_butterfly(2'd0, -16'sd2, 1'b1));
    for (int k = 0; k < 4; k++) begin
      pending_butterflies.push_back('{2'(k), 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                                      16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                                      1'b0});
      pending_butterflies.push_back('{2'(k), -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                                      -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                                      1'b1});
    end
    directed_cnt = pending_butterflies.size();
    n = 0;
    while (n < RandomItems) begin
      if ($urandom_range(0, 4) != 0) begin
        for (int k = 0; k < 4; k++) begin
          pending_butterflies.push_back(
            rand_butterfly(2'(k), (k == 3) && ($urandom_range(0, 3) == 0)));
        end
        n += 4;
      end else begin
        pending_butterflies.push_back(rand_butterfly(2'($urandom_range(0, 3)),
                                                     ($urandom_range(0, 7) == 0)));
        n++;
      end
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_butterflies.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    $display("Ran %0d butterflies (lanes 0..3: %0d/%0d/%0d/%0d, %0d end-of-batch marks),",
             accepted_count, lane_hits[0], lane_hits[1], lane_hits[2], lane_hits[3],
             eob_count);
    $display("checked %0d results under random gaps and stalls, %0d mismatches.",
             result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS radix4_fft_butterfly_q15");
    end else begin
      $display("FAIL radix4_fft_butterfly_q15");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rfb_pkg.sv
hw/rtl/radix4_fft_butterfly_q15.sv
sim/tb_radix4_fft_butterfly_q15.sv
